// ===== sv/nte_pkg.sv =====
`default_nettype none

package nte_pkg;

    // Default table depth and the limit on removals reported by one sweep.
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int MAX_RESULTS       = 16;
    localparam int KW                = $clog2(MAX_RESULTS + 1);

    // Result index that stands for no slot.
    localparam logic [4:0] RESULT_NIL = 5'h1F;

    // Operation codes carried by the mode field.
    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_FIND   = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_SWEEP  = 3'd3,
        MODE_SORT   = 3'd4
    } t_mode;

    // Micro-operations that the controller issues to the datapath.
    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_LOAD,
        UOP_INSERT,
        UOP_RES_PTR,
        UOP_RES_OK,
        UOP_STEP,
        UOP_ADV_PRE,
        UOP_UNHEAD,
        UOP_SPLICE,
        UOP_FREE,
        UOP_SWP_SKIP,
        UOP_SWP_ADV,
        UOP_SWP_TAKE,
        UOP_DEL_BEGIN,
        UOP_SWP_REC,
        UOP_SRT_INIT,
        UOP_SRT_LOAD,
        UOP_SRT_CUR,
        UOP_SRT_FRONT,
        UOP_SRT_LINK1,
        UOP_SRT_LINK2,
        UOP_SRT_DONE,
        UOP_EMIT
    } t_uop;

    // Command from controller to datapath.
    typedef struct packed {
        t_uop uop;
        logic last;
        logic live_cnt;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic ptr_nil;
        logic used_nil;
        logic item_nil;
        logic item_bad;
        logic item_is_head;
        logic link_is_item;
        logic addr_hit;
        logic expired;
        logic key_le;
        logic cur_nil;
        logic steps_full;
        logic guard_full;
        logic k_zero;
        logic k_full;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== sv/nte_datapath.sv =====
`default_nettype none

module nte_datapath #(
    parameter int TABLE_ENTRIES = nte_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  nte_pkg::t_cmd        i_cmd,
    output nte_pkg::t_status     o_status,
    input  wire  [2:0]           i_mode,
    input  wire  [15:0]          i_neighbor_address,
    input  wire  [31:0]          i_expire_time,
    input  wire  [31:0]          i_delivery_time,
    input  wire  signed [4:0]    i_entry_index,
    input  wire  [31:0]          i_current_time,
    input  wire                  i_out_stall,
    output logic                 o_out_valid,
    output logic signed [4:0]    o_result_index,
    output logic                 o_success,
    output logic [15:0]          o_removed_address,
    output logic                 o_removed_valid,
    output logic [4:0]           o_entry_count,
    output logic                 o_last
);

    localparam int LW = $clog2(TABLE_ENTRIES);
    localparam int PW = LW + 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    // A pointer carries a nil flag above the slot index.
    typedef logic [PW-1:0] t_ptr;
    localparam t_ptr PtrNil = {1'b1, {LW{1'b0}}};

    // Table storage.
    t_ptr        r_link     [TABLE_ENTRIES];
    logic [15:0] r_ent_addr [TABLE_ENTRIES];
    logic [31:0] r_ent_exp  [TABLE_ENTRIES];
    logic [31:0] r_ent_del  [TABLE_ENTRIES];

    // List heads and walk registers.
    t_ptr            r_free_head, r_used_head;
    t_ptr            r_ptr, r_pre, r_cur, r_head, r_nxt, r_item;
    logic            r_item_nil, r_item_bad;
    logic [CW-1:0]   r_count, r_steps, r_guard;
    logic [nte_pkg::KW-1:0] r_k;
    logic [31:0]     r_key;
    logic [15:0]     r_gone;

    // Latched request.
    logic [15:0]     r_req_addr;
    logic [31:0]     r_req_exp, r_req_del, r_now;

    // Pending result.
    t_ptr            r_res_idx;
    logic            r_res_ok, r_res_valid;
    logic [15:0]     r_res_addr;
    logic [CW-1:0]   r_res_cnt;

    // Output register.
    logic            r_out_valid;
    logic [4:0]      r_out_idx;
    logic            r_out_ok, r_out_rvalid, r_out_last;
    logic [15:0]     r_out_addr;
    logic [4:0]      r_out_cnt;

    // All table reads share one address, the walk pointer.
    logic [LW-1:0] rd_idx;
    t_ptr          rd_link;
    logic [15:0]   rd_addr;
    logic [31:0]   rd_exp, rd_del;
    logic          in_item_nil, in_item_bad, out_free;

    assign rd_idx  = r_ptr[LW-1:0];
    assign rd_link = r_link[rd_idx];
    assign rd_addr = r_ent_addr[rd_idx];
    assign rd_exp  = r_ent_exp[rd_idx];
    assign rd_del  = r_ent_del[rd_idx];

    // Decode of the slot to delete.
    assign in_item_nil = (i_entry_index == nte_pkg::RESULT_NIL);
    assign in_item_bad = !in_item_nil &&
                         (i_entry_index[4] || (int'(i_entry_index[3:0]) >= TABLE_ENTRIES));

    assign out_free = !r_out_valid || !i_out_stall;

    // Status toward the controller.
    always_comb begin
        o_status.ptr_nil      = r_ptr[LW];
        o_status.used_nil     = r_used_head[LW];
        o_status.item_nil     = r_item_nil;
        o_status.item_bad     = r_item_bad;
        o_status.item_is_head = (r_item == r_used_head);
        o_status.link_is_item = (rd_link == r_item);
        o_status.addr_hit     = (rd_addr == r_req_addr);
        o_status.expired      = (rd_exp < r_now);
        o_status.key_le       = (r_key <= rd_del);
        o_status.cur_nil      = r_cur[LW];
        o_status.steps_full   = (r_steps == CW'(TABLE_ENTRIES));
        o_status.guard_full   = (r_guard == CW'(TABLE_ENTRIES));
        o_status.k_zero       = (r_k == '0);
        o_status.k_full       = (r_k == nte_pkg::KW'(nte_pkg::MAX_RESULTS));
        o_status.out_free     = out_free;
    end

    // Link table: one write per cycle, reset to the initial free chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
                r_link[i] <= {1'b0, LW'(i + 1)};
            end
            r_link[TABLE_ENTRIES-1] <= PtrNil;
        end else begin
            unique case (i_cmd.uop)
                nte_pkg::UOP_INSERT:    r_link[rd_idx] <= r_used_head;
                nte_pkg::UOP_SPLICE:    r_link[r_pre[LW-1:0]] <= rd_link;
                nte_pkg::UOP_FREE:      r_link[r_item[LW-1:0]] <= r_free_head;
                nte_pkg::UOP_SRT_INIT:  r_link[rd_idx] <= PtrNil;
                nte_pkg::UOP_SRT_FRONT: r_link[r_cur[LW-1:0]] <= r_head;
                nte_pkg::UOP_SRT_LINK1: r_link[r_cur[LW-1:0]] <= r_ptr;
                nte_pkg::UOP_SRT_LINK2: r_link[r_pre[LW-1:0]] <= r_cur;
                default: ;
            endcase
        end
    end

    // Entry payload, written on insert only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == nte_pkg::UOP_INSERT) begin
            r_ent_addr[rd_idx] <= r_req_addr;
            r_ent_exp[rd_idx]  <= r_req_exp;
            r_ent_del[rd_idx]  <= r_req_del;
        end
    end

    // List heads, used count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_used_head <= PtrNil;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd.uop)
                nte_pkg::UOP_INSERT: begin
                    r_free_head <= rd_link;
                    r_used_head <= r_ptr;
                    r_count     <= r_count + 1'b1;
                end
                nte_pkg::UOP_UNHEAD:   r_used_head <= rd_link;
                nte_pkg::UOP_FREE: begin
                    r_free_head <= r_item;
                    r_count     <= r_count - 1'b1;
                end
                nte_pkg::UOP_SRT_DONE: r_used_head <= r_head;
                default: ;
            endcase
            if (i_cmd.uop == nte_pkg::UOP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk registers, request latch and pending result.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.uop)
            nte_pkg::UOP_LOAD: begin
                r_ptr       <= (i_mode == nte_pkg::MODE_INSERT) ? r_free_head : r_used_head;
                r_steps     <= '0;
                r_guard     <= '0;
                r_k         <= '0;
                r_req_addr  <= i_neighbor_address;
                r_req_exp   <= i_expire_time;
                r_req_del   <= i_delivery_time;
                r_now       <= i_current_time;
                r_item      <= {1'b0, LW'(i_entry_index[3:0])};
                r_item_nil  <= in_item_nil;
                r_item_bad  <= in_item_bad;
                r_res_idx   <= PtrNil;
                r_res_ok    <= 1'b0;
                r_res_addr  <= '0;
                r_res_valid <= 1'b0;
                r_res_cnt   <= '0;
            end
            nte_pkg::UOP_INSERT:  r_res_idx <= r_ptr;
            nte_pkg::UOP_RES_PTR: r_res_idx <= r_ptr;
            nte_pkg::UOP_RES_OK:  r_res_ok  <= 1'b1;
            nte_pkg::UOP_FREE:    r_res_ok  <= 1'b1;
            nte_pkg::UOP_STEP: begin
                r_ptr   <= rd_link;
                r_steps <= r_steps + 1'b1;
            end
            nte_pkg::UOP_ADV_PRE: begin
                r_pre <= r_ptr;
                r_ptr <= rd_link;
            end
            nte_pkg::UOP_SWP_SKIP: begin
                r_ptr   <= rd_link;
                r_guard <= r_guard + 1'b1;
            end
            nte_pkg::UOP_SWP_ADV: begin
                r_ptr   <= r_nxt;
                r_guard <= r_guard + 1'b1;
            end
            nte_pkg::UOP_SWP_TAKE: begin
                r_nxt      <= rd_link;
                r_gone     <= rd_addr;
                r_item     <= r_ptr;
                r_item_nil <= 1'b0;
                r_item_bad <= 1'b0;
            end
            nte_pkg::UOP_DEL_BEGIN: begin
                r_ptr   <= r_used_head;
                r_steps <= '0;
            end
            nte_pkg::UOP_SWP_REC: begin
                r_res_idx   <= PtrNil;
                r_res_ok    <= 1'b1;
                r_res_addr  <= r_gone;
                r_res_valid <= 1'b1;
                r_res_cnt   <= r_count;
                r_k         <= r_k + 1'b1;
                r_ptr       <= r_nxt;
                r_guard     <= r_guard + 1'b1;
            end
            nte_pkg::UOP_SRT_INIT: begin
                r_head  <= r_ptr;
                r_cur   <= rd_link;
                r_guard <= '0;
            end
            nte_pkg::UOP_SRT_LOAD: r_ptr <= r_cur;
            nte_pkg::UOP_SRT_CUR: begin
                r_nxt <= rd_link;
                r_key <= rd_del;
                r_ptr <= r_head;
            end
            nte_pkg::UOP_SRT_FRONT: begin
                r_head  <= r_cur;
                r_cur   <= r_nxt;
                r_guard <= r_guard + 1'b1;
            end
            nte_pkg::UOP_SRT_LINK2: begin
                r_cur   <= r_nxt;
                r_guard <= r_guard + 1'b1;
            end
            default: ;
        endcase
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == nte_pkg::UOP_EMIT) begin
            r_out_idx    <= r_res_idx[LW] ? nte_pkg::RESULT_NIL : 5'(r_res_idx[LW-1:0]);
            r_out_ok     <= r_res_ok;
            r_out_addr   <= r_res_addr;
            r_out_rvalid <= r_res_valid;
            r_out_cnt    <= i_cmd.live_cnt ? 5'(r_count) : 5'(r_res_cnt);
            r_out_last   <= i_cmd.last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_index    = r_out_idx;
    assign o_success         = r_out_ok;
    assign o_removed_address = r_out_addr;
    assign o_removed_valid   = r_out_rvalid;
    assign o_entry_count     = r_out_cnt;
    assign o_last            = r_out_last;

endmodule

`default_nettype wire

// ===== sv/nte_ctrl.sv =====
`default_nettype none

module nte_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire  [2:0]       i_mode,
    input  nte_pkg::t_status i_status,
    output nte_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS,
        S_FIND,
        S_DEL,
        S_WALK,
        S_SPLICE,
        S_FREE,
        S_SWP,
        S_SWP_FLUSH,
        S_SWP_TAKE,
        S_DEL_BEGIN,
        S_SWP_REC,
        S_SWP_END,
        S_SRT_INIT,
        S_SRT_LOOP,
        S_SRT_CUR,
        S_SRT_CMP,
        S_SRT_SCAN,
        S_SRT_LINK2,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_sweep, n_sweep;

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and micro-operation.
    always_comb begin
        n_state        = r_state;
        n_sweep        = r_sweep;
        o_cmd.uop      = nte_pkg::UOP_NONE;
        o_cmd.last     = 1'b1;
        o_cmd.live_cnt = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.uop = nte_pkg::UOP_LOAD;
                    n_sweep   = 1'b0;
                    unique case (nte_pkg::t_mode'(i_mode))
                        nte_pkg::MODE_INSERT: n_state = S_INS;
                        nte_pkg::MODE_FIND:   n_state = S_FIND;
                        nte_pkg::MODE_DELETE: n_state = S_DEL;
                        nte_pkg::MODE_SWEEP: begin
                            n_state = S_SWP;
                            n_sweep = 1'b1;
                        end
                        nte_pkg::MODE_SORT:   n_state = S_SRT_INIT;
                        default:              n_state = S_EMIT;
                    endcase
                end
            end
            S_INS: begin
                if (!i_status.ptr_nil) begin
                    o_cmd.uop = nte_pkg::UOP_INSERT;
                end
                n_state = S_EMIT;
            end
            // Search by address, one hop per cycle.
            S_FIND: begin
                priority if (i_status.ptr_nil || i_status.steps_full) begin
                    n_state = S_EMIT;
                end else if (i_status.addr_hit) begin
                    o_cmd.uop = nte_pkg::UOP_RES_PTR;
                    n_state   = S_EMIT;
                end else begin
                    o_cmd.uop = nte_pkg::UOP_STEP;
                end
            end
            // Unlink of one slot, shared by delete and sweep.
            S_DEL: begin
                priority if (i_status.item_nil) begin
                    o_cmd.uop = nte_pkg::UOP_RES_OK;
                    n_state   = S_EMIT;
                end else if (i_status.item_bad || i_status.used_nil) begin
                    n_state = S_EMIT;
                end else if (i_status.item_is_head) begin
                    o_cmd.uop = nte_pkg::UOP_UNHEAD;
                    n_state   = S_FREE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                priority if (i_status.ptr_nil || i_status.steps_full) begin
                    if (r_sweep) begin
                        o_cmd.uop = nte_pkg::UOP_SWP_ADV;
                        n_state   = S_SWP;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else if (i_status.link_is_item) begin
                    o_cmd.uop = nte_pkg::UOP_ADV_PRE;
                    n_state   = S_SPLICE;
                end else begin
                    o_cmd.uop = nte_pkg::UOP_STEP;
                end
            end
            S_SPLICE: begin
                o_cmd.uop = nte_pkg::UOP_SPLICE;
                n_state   = S_FREE;
            end
            S_FREE: begin
                o_cmd.uop = nte_pkg::UOP_FREE;
                n_state   = r_sweep ? S_SWP_REC : S_EMIT;
            end
            // Expiry sweep; a removal is held until the next one shows it is not last.
            S_SWP: begin
                priority if (i_status.ptr_nil || i_status.guard_full || i_status.k_full) begin
                    n_state = S_SWP_END;
                end else if (i_status.expired) begin
                    n_state = S_SWP_FLUSH;
                end else begin
                    o_cmd.uop = nte_pkg::UOP_SWP_SKIP;
                end
            end
            S_SWP_FLUSH: begin
                priority if (i_status.k_zero) begin
                    o_cmd.uop = nte_pkg::UOP_SWP_TAKE;
                    n_state   = S_DEL_BEGIN;
                end else if (i_status.out_free) begin
                    o_cmd.uop      = nte_pkg::UOP_EMIT;
                    o_cmd.last     = 1'b0;
                    o_cmd.live_cnt = 1'b0;
                    n_state        = S_SWP_TAKE;
                end else begin
                    n_state = S_SWP_FLUSH;
                end
            end
            S_SWP_TAKE: begin
                o_cmd.uop = nte_pkg::UOP_SWP_TAKE;
                n_state   = S_DEL_BEGIN;
            end
            S_DEL_BEGIN: begin
                o_cmd.uop = nte_pkg::UOP_DEL_BEGIN;
                n_state   = S_DEL;
            end
            S_SWP_REC: begin
                o_cmd.uop = nte_pkg::UOP_SWP_REC;
                n_state   = S_SWP;
            end
            S_SWP_END: begin
                priority if (i_status.k_zero) begin
                    n_state = S_EMIT;
                end else if (i_status.out_free) begin
                    o_cmd.uop      = nte_pkg::UOP_EMIT;
                    o_cmd.live_cnt = 1'b0;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_SWP_END;
                end
            end
            // Insertion sort of the used list by delivery tick.
            S_SRT_INIT: begin
                if (!i_status.used_nil) begin
                    o_cmd.uop = nte_pkg::UOP_SRT_INIT;
                    n_state   = S_SRT_LOOP;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SRT_LOOP: begin
                if (i_status.cur_nil || i_status.guard_full) begin
                    o_cmd.uop = nte_pkg::UOP_SRT_DONE;
                    n_state   = S_EMIT;
                end else begin
                    o_cmd.uop = nte_pkg::UOP_SRT_LOAD;
                    n_state   = S_SRT_CUR;
                end
            end
            S_SRT_CUR: begin
                o_cmd.uop = nte_pkg::UOP_SRT_CUR;
                n_state   = S_SRT_CMP;
            end
            S_SRT_CMP: begin
                if (i_status.key_le) begin
                    o_cmd.uop = nte_pkg::UOP_SRT_FRONT;
                    n_state   = S_SRT_LOOP;
                end else begin
                    o_cmd.uop = nte_pkg::UOP_ADV_PRE;
                    n_state   = S_SRT_SCAN;
                end
            end
            S_SRT_SCAN: begin
                if (i_status.ptr_nil || i_status.key_le) begin
                    o_cmd.uop = nte_pkg::UOP_SRT_LINK1;
                    n_state   = S_SRT_LINK2;
                end else begin
                    o_cmd.uop = nte_pkg::UOP_ADV_PRE;
                end
            end
            S_SRT_LINK2: begin
                o_cmd.uop = nte_pkg::UOP_SRT_LINK2;
                n_state   = S_SRT_LOOP;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.uop = nte_pkg::UOP_EMIT;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sweep <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
        end
    end

endmodule

`default_nettype wire

// ===== sv/neighbor_table_engine.sv =====
// Channel  Direction  Handshake                 Beat contents
// in       input      i_in_valid / o_in_stall   mode, address, expiry, delivery, index, time
// out      output     o_out_valid / i_out_stall index, success, removed address, count, last
//
// One command at a time; the link table has a single read port, one list hop per cycle.
// Find and delete walk the used list from its head, and sort reorders the used entries by
// delivery time. A sweep steps past each kept entry; a removal behind kept entries walks
// again from the list head past each entry ahead of it, then splices it out.
// Reset is synchronous and rebuilds the free chain at once; no clearing pass is needed.
// A new command is taken while the last beat still waits; a stalled output holds a
// command only once it has a beat of its own ready to send.
`default_nettype none

module neighbor_table_engine #(
    parameter int TABLE_ENTRIES = nte_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  [2:0]         i_mode,
    input  wire  [15:0]        i_neighbor_address,
    input  wire  [31:0]        i_expire_time,
    input  wire  [31:0]        i_delivery_time,
    input  wire  signed [4:0]  i_entry_index,
    input  wire  [31:0]        i_current_time,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [4:0]  o_result_index,
    output logic               o_success,
    output logic [15:0]        o_removed_address,
    output logic               o_removed_valid,
    output logic [4:0]         o_entry_count,
    output logic               o_last
);

    nte_pkg::t_cmd    cmd;
    nte_pkg::t_status status;

    // Sequencer.
    nte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (i_mode),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Table, walk registers and output register.
    nte_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_mode             (i_mode),
        .i_neighbor_address (i_neighbor_address),
        .i_expire_time      (i_expire_time),
        .i_delivery_time    (i_delivery_time),
        .i_entry_index      (i_entry_index),
        .i_current_time     (i_current_time),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_result_index     (o_result_index),
        .o_success          (o_success),
        .o_removed_address  (o_removed_address),
        .o_removed_valid    (o_removed_valid),
        .o_entry_count      (o_entry_count),
        .o_last             (o_last)
    );

endmodule

`default_nettype wire

// ===== sv/nte_checker.sv =====
`default_nettype none

module nte_checker #(
    parameter int TABLE_ENTRIES = nte_pkg::TABLE_ENTRIES_DEF
) (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               o_in_stall,
    input wire               o_out_valid,
    input wire               i_out_stall,
    input wire signed [4:0]  o_result_index,
    input wire               o_success,
    input wire [15:0]        o_removed_address,
    input wire               o_removed_valid,
    input wire [4:0]         o_entry_count,
    input wire               o_last
);

    // A stalled beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_index) &&
        $stable(o_success) && $stable(o_removed_address) && $stable(o_removed_valid) &&
        $stable(o_entry_count) && $stable(o_last))
        else $error("output beat changed under stall");

    // The count never exceeds the table.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_entry_count) <= TABLE_ENTRIES))
        else $error("entry count beyond table size");

    // A removal beat reports success and no slot.
    a_removal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_removed_valid |-> o_success && (o_result_index == nte_pkg::RESULT_NIL))
        else $error("removal beat with bad fields");

    // A taken command raises the input stall in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken back to back");

endmodule

bind neighbor_table_engine nte_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_nte_checker (.*);

`default_nettype wire
